[design/vsp_pkg.sv]
`default_nettype none

package vsp_pkg;

    localparam int BYTE_W = 8;
    localparam int PART_W = 14;
    localparam int PROD_W = PART_W + 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [PART_W-1:0] PART_LIMIT = PART_W'(9999);

    localparam logic [BYTE_W-1:0] CHAR_NUL    = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_DOT    = 8'h2E;
    localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE   = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_V_UP   = 8'h56;
    localparam logic [BYTE_W-1:0] CHAR_V_LOW  = 8'h76;

    localparam logic [CFG_IDX_W-1:0] CFG_V_PREFIX_EN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUFFIX_EN   = 1'b1;

    typedef struct packed {
        logic              ok;
        logic [PART_W-1:0] major;
        logic [PART_W-1:0] minor;
        logic [PART_W-1:0] patch;
    } result_t;

    typedef struct packed {
        logic v_prefix_en;
        logic suffix_en;
    } cfg_t;

endpackage

`default_nettype wire

[design/version_string_parser_unit.sv]
// A terminator byte passes the input register, then the output register.
// Throughput: one byte per cycle; a terminator waits only while the previous
// result is held in the output register under stall.
// Reset (rst_n, async, active low): parser returns to start of string, output
// register empties, both configuration bits return to 1.
`default_nettype none

module version_string_parser_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [vsp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic                          cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [vsp_pkg::BYTE_W-1:0]    char_byte,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               parse_ok,
    output logic [vsp_pkg::PART_W-1:0]         major_part,
    output logic [vsp_pkg::PART_W-1:0]         minor_part,
    output logic [vsp_pkg::PART_W-1:0]         patch_part
);

    vsp_pkg::cfg_t              cfg_reg, cfg_next;
    logic                       held_valid;
    logic [vsp_pkg::BYTE_W-1:0] held_byte;
    logic                       pull;
    vsp_pkg::result_t           result;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                vsp_pkg::CFG_V_PREFIX_EN: cfg_next.v_prefix_en = cfg_data;
                vsp_pkg::CFG_SUFFIX_EN:   cfg_next.suffix_en   = cfg_data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{v_prefix_en: 1'b1, suffix_en: 1'b1};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    vsp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_byte  (char_byte),
        .pull       (pull),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    vsp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .held_valid (held_valid),
        .held_byte  (held_byte),
        .pull       (pull),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result     (result)
    );

    assign parse_ok   = result.ok;
    assign major_part = result.major;
    assign minor_part = result.minor;
    assign patch_part = result.patch;

endmodule

`default_nettype wire

[design/vsp_in_reg.sv]
`default_nettype none

module vsp_in_reg (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [vsp_pkg::BYTE_W-1:0] char_byte,
    input  wire logic                      pull,
    output logic                           held_valid,
    output logic [vsp_pkg::BYTE_W-1:0]     held_byte
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [vsp_pkg::BYTE_W-1:0] byte_reg;
    logic                       load;

    assign in_stall = valid_reg && !pull;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (pull)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= char_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

`default_nettype wire

[design/vsp_parser.sv]
`default_nettype none

module vsp_parser (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire vsp_pkg::cfg_t              cfg,
    input  wire logic                       held_valid,
    input  wire logic [vsp_pkg::BYTE_W-1:0] held_byte,
    output logic                            pull,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output vsp_pkg::result_t                result
);

    typedef enum logic [2:0] {
        PH_START,
        PH_MAJOR,
        PH_MINOR,
        PH_PATCH,
        PH_SUFFIX
    } phase_t;

    phase_t                     phase_reg, phase_next, phase_eff;
    logic [vsp_pkg::PART_W-1:0] acc_reg, acc_next;
    logic [vsp_pkg::PART_W-1:0] major_reg, major_next;
    logic [vsp_pkg::PART_W-1:0] minor_reg, minor_next;
    logic                       seen_reg, seen_next;
    logic                       failed_reg, failed_next;
    logic                       out_valid_reg, out_valid_next;
    vsp_pkg::result_t           result_reg, result_next;

    logic                        is_term;
    logic                        is_digit;
    logic                        is_dot;
    logic                        is_v;
    logic                        comp;
    logic [vsp_pkg::PROD_W-1:0]  prod;
    logic                        ok;

    assign is_term  = (held_byte == vsp_pkg::CHAR_NUL);
    assign is_digit = (held_byte >= vsp_pkg::CHAR_ZERO) && (held_byte <= vsp_pkg::CHAR_NINE);
    assign is_dot   = (held_byte == vsp_pkg::CHAR_DOT);
    assign is_v     = (held_byte == vsp_pkg::CHAR_V_LOW) || (held_byte == vsp_pkg::CHAR_V_UP);
    assign prod     = vsp_pkg::PROD_W'(acc_reg) * vsp_pkg::PROD_W'(10)
                    + vsp_pkg::PROD_W'(held_byte[3:0]);

    // a terminator waits while the previous result is still held
    assign pull = held_valid && !(is_term && out_valid_reg && out_stall);
    assign ok   = !failed_reg && (((phase_reg == PH_PATCH) && seen_reg)
                                  || (phase_reg == PH_SUFFIX));

    always_comb
    begin
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        major_next     = major_reg;
        minor_next     = minor_reg;
        seen_next      = seen_reg;
        failed_next    = failed_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && out_stall;
        phase_eff      = phase_reg;
        comp           = 1'b0;

        if (pull)
        begin
            if (is_term)
            begin
                out_valid_next     = 1'b1;
                result_next.ok     = ok;
                result_next.major  = ok ? major_reg : '0;
                result_next.minor  = ok ? minor_reg : '0;
                result_next.patch  = ok ? acc_reg : '0;
                phase_next         = PH_START;
                acc_next           = '0;
                major_next         = '0;
                minor_next         = '0;
                seen_next          = 1'b0;
                failed_next        = 1'b0;
            end
            else if (!failed_reg)
            begin
                case (phase_reg)
                    PH_START:
                    begin
                        phase_eff  = PH_MAJOR;
                        phase_next = PH_MAJOR;
                        comp       = !(cfg.v_prefix_en && is_v);
                    end
                    PH_MAJOR, PH_MINOR, PH_PATCH:
                    begin
                        comp = 1'b1;
                    end
                    PH_SUFFIX:
                    begin
                        comp = 1'b0;
                    end
                    default:
                    begin
                        failed_next = 1'b1;
                    end
                endcase

                if (comp)
                begin
                    if (is_digit)
                    begin
                        if (prod > vsp_pkg::PROD_W'(vsp_pkg::PART_LIMIT))
                        begin
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            acc_next  = prod[vsp_pkg::PART_W-1:0];
                            seen_next = 1'b1;
                        end
                    end
                    else if (!seen_reg)
                    begin
                        failed_next = 1'b1;
                    end
                    else if (phase_eff == PH_PATCH)
                    begin
                        if (cfg.suffix_en && !is_dot)
                        begin
                            phase_next = PH_SUFFIX;
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    else if (!is_dot)
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        if (phase_eff == PH_MAJOR)
                        begin
                            major_next = acc_reg;
                            phase_next = PH_MINOR;
                        end
                        else
                        begin
                            minor_next = acc_reg;
                            phase_next = PH_PATCH;
                        end
                        acc_next  = '0;
                        seen_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            acc_reg       <= '0;
            major_reg     <= '0;
            minor_reg     <= '0;
            seen_reg      <= 1'b0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            major_reg     <= major_next;
            minor_reg     <= minor_next;
            seen_reg      <= seen_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
            result_reg    <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire
